FILE: hw/rtl/bsst_pkg.sv
// Shared constants and controller/datapath interface types for the span tracker.
`timescale 1ns / 1ps

package bsst_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 7;
  localparam int VAL_W       = 32;
  localparam int GAP_W       = VAL_W + 1;
  localparam int OUT_DATA_W  = 80;

  // Commands from the controller, at most one per cycle
  typedef struct packed {
    logic load;    // capture an input beat
    logic rd;      // read the entry just below the hole
    logic cmp;     // compare read entry, shift it up or stop
    logic merge;   // fold the upper neighbor gap into the minimum
    logic place;   // write the value into the hole, update count, gap minimum and extremes
    logic report;  // load the output register
  } bsst_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic room;      // store below effective capacity
    logic empty;     // nothing held yet
    logic greater;   // read entry is above the new value
    logic idx_one;   // hole sits at index 1
    logic out_free;  // output register can take a result
  } bsst_sts_t;

endpackage

FILE: hw/rtl/bsst_ctrl.sv
// Controller state machine for the insertion walk of the span tracker.
`timescale 1ns / 1ps

module bsst_ctrl
  import bsst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bsst_sts_t sts,
  output bsst_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_MERGE,
    ST_PLACE,
    ST_REPORT
  } state_t;

  state_t state;
  state_t state_next;

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.room) begin
            state_next = ST_REPORT;
          end else if (sts.empty) begin
            state_next = ST_MERGE;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.greater && !sts.idx_one) begin
          state_next = ST_RD;
        end else begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = ST_PLACE;
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/bsst_dpath.sv
// Datapath: sorted store, running gap minimum, extremes and output register.
`timescale 1ns / 1ps

module bsst_dpath
  import bsst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  bsst_cmd_t             cmd,
  output bsst_sts_t             sts,
  input  logic [VAL_W-1:0]      in_value,
  input  logic                  in_last,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_capacity,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last
);

  localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_ENTRIES);

  // Sorted store, ascending from index 0
  logic [VAL_W-1:0] mem [MAX_ENTRIES];

  logic [CNT_W-1:0]        capacity;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        idx;      // current hole in the store
  logic signed [VAL_W-1:0] val;
  logic                    last;
  logic                    acc;
  logic signed [VAL_W-1:0] rd_data;
  logic                    have_hi;
  logic                    have_lo;
  logic [VAL_W-1:0]        hi_gap;
  logic [VAL_W-1:0]        lo_gap;
  logic [GAP_W-1:0]        gap;
  logic signed [VAL_W-1:0] smallest;
  logic signed [VAL_W-1:0] largest;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             we;
  logic             greater;
  logic [GAP_W-1:0] diff_up;
  logic [GAP_W-1:0] diff_dn;
  logic             span_ok;
  logic [VAL_W-1:0] span_long;

  // Status
  assign greater      = rd_data > val;
  assign sts.room     = (count < capacity) && (count < MaxCount);
  assign sts.empty    = (count == '0);
  assign sts.greater  = greater;
  assign sts.idx_one  = (idx == CNT_W'(1));
  assign sts.out_free = !out_valid || out_ready;

  // Exact differences; both fit in 32 unsigned bits
  assign diff_up = {rd_data[VAL_W-1], rd_data} - {val[VAL_W-1], val};
  assign diff_dn = {val[VAL_W-1], val} - {rd_data[VAL_W-1], rd_data};

  // Store port: shifted entry during the walk, new value on place
  assign rd_addr = IDX_W'(idx - CNT_W'(1));
  assign wr_addr = idx[IDX_W-1:0];
  assign we      = (cmd.cmp && greater) || cmd.place;
  assign wr_data = cmd.place ? val : rd_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_capacity;
    end
  end

  // Item capture and insertion walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val     <= in_value;
      last    <= in_last;
      acc     <= sts.room;
      idx     <= count;
      have_hi <= 1'b0;
      have_lo <= 1'b0;
    end
    if (cmd.cmp) begin
      if (greater) begin
        idx     <= idx - CNT_W'(1);
        have_hi <= 1'b1;
        hi_gap  <= diff_up[VAL_W-1:0];
      end else begin
        have_lo <= 1'b1;
        lo_gap  <= diff_dn[VAL_W-1:0];
      end
    end
  end

  // Set statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      gap      <= '1;
      smallest <= '0;
      largest  <= '0;
    end else begin
      if (cmd.merge && have_hi && ({1'b0, hi_gap} < gap)) begin
        gap <= {1'b0, hi_gap};
      end
      if (cmd.place) begin
        count <= count + CNT_W'(1);
        if (have_lo && ({1'b0, lo_gap} < gap)) begin
          gap <= {1'b0, lo_gap};
        end
        if (sts.empty || (val < smallest)) begin
          smallest <= val;
        end
        if (sts.empty || (val >= largest)) begin
          largest <= val;
        end
      end
    end
  end

  // Result fields
  assign span_ok   = (count >= CNT_W'(2));
  assign span_long = VAL_W'(largest - smallest);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_data <= {6'b0, count,
                   span_ok ? span_long : '0,
                   span_ok ? gap[VAL_W-1:0] : '0,
                   span_ok, !acc, acc};
      out_last <= last;
    end
  end

endmodule

FILE: hw/rtl/bounded_set_span_tracker.sv
// Top level of the bounded sorted-set span tracker.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: value; tlast: last_in_batch
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result fields; tlast: batch_done
//  cfg       in   cfg_valid/cfg_ready          cfg_data: capacity
//
// One item at a time. An accepted beat runs a read and a compare step per compare, then merge,
// place and report steps, before its result can be taken; compares are one per held entry above
// the value, plus one for the entry just below it when there is one (at most 63 compares with
// 63 held); the walk reads one store entry per compare through the store's read port. A rejected
// item goes from its beat straight to the report step.
// Reset clears count, gap minimum, extremes and capacity; the store needs no
// clearing pass. A stalled result holds the block in its report step.
`timescale 1ns / 1ps

module bounded_set_span_tracker
  import bsst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VAL_W-1:0]      s_axis_tdata,   // [31:0] value
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] accepted, [1] full_error, [2] span_valid, [34:3] shortest_span,
  // [66:35] longest_span, [73:67] held_count, [79:74] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data
);

  bsst_cmd_t cmd;
  bsst_sts_t sts;

  assign cfg_ready = 1'b1;

  bsst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsst_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (s_axis_tdata),
    .in_last      (s_axis_tlast),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (cfg_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_data     (m_axis_tdata),
    .out_last     (m_axis_tlast)
  );

  // Controller never issues two commands at once
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("multiple datapath commands");

  // A taken beat makes the block busy the next cycle
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // Exactly one of accepted and full_error in every result
  a_acc_xor_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] != m_axis_tdata[1]))
    else $error("accepted and full_error disagree");

  // Held count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[73:67] <= CNT_W'(MAX_ENTRIES)))
    else $error("held count beyond store depth");

endmodule
